### hw/rtl/rhsl_pkg.sv
// ----------------------------------------------------------------------------
// rhsl_pkg: shared types and constants for the RGB to HSL converter
// Pixel and result item layouts, output limits and divider geometry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rhsl_pkg;

  localparam int CH_W  = 8;
  localparam int HUE_W = 13;
  localparam int PCT_W = 15;

  localparam logic [HUE_W-1:0] HUE_MAX = 13'd5760;
  localparam logic [PCT_W-1:0] PCT_MAX = 15'd25600;

  // Hue sector offsets in sixteenths of a degree.
  localparam logic [HUE_W-1:0] HUE_BASE_RED  = 13'd0;
  localparam logic [HUE_W-1:0] HUE_BASE_WRAP = 13'd5760;
  localparam logic [HUE_W-1:0] HUE_BASE_GRN  = 13'd1920;
  localparam logic [HUE_W-1:0] HUE_BASE_BLU  = 13'd3840;

  // Restoring divider: 15 quotient bits over an 8-bit divisor.
  localparam int DIV_QUO_W = 15;
  localparam int DIV_DEN_W = 8;
  localparam int DIV_NUM_W = DIV_QUO_W + DIV_DEN_W;

  // floor(25600*t/510) = (t * 2560 * ceil(2^27/51)) >> 27, exact for t <= 510.
  localparam int          LUM_SHIFT = 27;
  localparam int          LUM_PROD_W = 42;
  localparam logic [32:0] LUM_MAGIC = 33'd6737205760;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] saturation;
    logic [PCT_W-1:0] luminance;
  } hsl_t;

endpackage

### hw/rtl/rhsl_div.sv
// ----------------------------------------------------------------------------
// rhsl_div: pipelined restoring divider
// One quotient bit per stage, each stage advanced by its own enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhsl_div import rhsl_pkg::*; #(
  parameter int NUM_W = DIV_NUM_W,
  parameter int DEN_W = DIV_DEN_W,
  parameter int QUO_W = DIV_QUO_W
) (
  input  logic             clk,
  input  logic [QUO_W-1:0] en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output logic             rem_nz
);

  // Requires num < den * 2**QUO_W.
  logic [NUM_W-1:0] rem  [QUO_W];
  logic [DEN_W-1:0] dvs  [QUO_W];
  logic [QUO_W-1:0] quot [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    logic [NUM_W-1:0] rem_in;
    logic [NUM_W-1:0] dvs_sh;
    logic [DEN_W-1:0] dvs_in;
    logic [QUO_W-1:0] quo_in;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign dvs_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem[i-1];
      assign dvs_in = dvs[i-1];
      assign quo_in = quot[i-1];
    end

    assign dvs_sh = NUM_W'(dvs_in) << (QUO_W - 1 - i);
    assign ge     = rem_in >= dvs_sh;

    always_ff @(posedge clk) begin
      if (en[i]) begin
        rem[i]  <= ge ? rem_in - dvs_sh : rem_in;
        dvs[i]  <= dvs_in;
        quot[i] <= quo_in | ({{(QUO_W-1){1'b0}}, ge} << (QUO_W - 1 - i));
      end
    end
  end

  assign quo    = quot[QUO_W-1];
  assign rem_nz = |rem[QUO_W-1];

endmodule

### hw/rtl/rgb_to_hsl_converter_core.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_core: 8-bit RGB pixel to hue / saturation / luminance
// Stages: prep, divide, output; both divisions are one-bit-per-stage pipelines.
// Throughput: one item per cycle whenever the output is not stalling.
// Stalls collapse bubbles stage by stage; the input stalls only when all are full.
// Reset (rst, synchronous) clears the stage valid bits; data registers keep junk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_to_hsl_converter_core import rhsl_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   pix_valid,
  output logic   pix_stall,
  input  pixel_t pix,
  output logic   hsl_valid,
  input  logic   hsl_stall,
  output hsl_t   hsl
);

  // Stage map: 0 = classify, 1 = numerators + luminance, 2..16 = divide,
  // 17 = hue fixup, clamps, output register.
  localparam int NSTG   = DIV_QUO_W + 3;
  localparam int DIV_LO = 2;

  typedef struct packed {
    logic             gray;   // all channels equal
    logic             neg;    // hue numerator is negative
    logic [HUE_W-1:0] base;   // sector offset
    logic [PCT_W-1:0] lum;
  } side_t;

  typedef struct packed {
    logic             gray;
    logic             neg;
    logic [HUE_W-1:0] base;
    logic [CH_W-1:0]  anum;   // |hue numerator channel difference|
    logic [CH_W-1:0]  d;      // max - min
    logic [CH_W:0]    t;      // max + min
  } cls_t;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;

  // --------------------------------------------------------------------------
  // Flow control: a stage loads when it is empty or its successor moves.
  // --------------------------------------------------------------------------
  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || !hsl_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign pix_stall = !adv[0];
  assign hsl_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= pix_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: max/min, sector, absolute numerator. Ties: red > green > blue.
  // --------------------------------------------------------------------------
  cls_t            cls_next;
  cls_t            cls;
  logic [CH_W-1:0] mx;
  logic [CH_W-1:0] mn;

  always_comb begin
    cls_next = '0;
    mn = pix.red;
    if (pix.green < mn) mn = pix.green;
    if (pix.blue < mn) mn = pix.blue;

    if (pix.red >= pix.green && pix.red >= pix.blue) begin
      mx = pix.red;
      if (pix.green >= pix.blue) begin
        cls_next.anum = pix.green - pix.blue;
        cls_next.neg  = 1'b0;
        cls_next.base = HUE_BASE_RED;
      end else begin
        // wraps from 360 degrees downward
        cls_next.anum = pix.blue - pix.green;
        cls_next.neg  = 1'b1;
        cls_next.base = HUE_BASE_WRAP;
      end
    end else if (pix.green >= pix.blue) begin
      mx = pix.green;
      cls_next.base = HUE_BASE_GRN;
      cls_next.neg  = pix.blue < pix.red;
      cls_next.anum = cls_next.neg ? pix.red - pix.blue : pix.blue - pix.red;
    end else begin
      mx = pix.blue;
      cls_next.base = HUE_BASE_BLU;
      cls_next.neg  = pix.green > pix.red;
      cls_next.anum = cls_next.neg ? pix.green - pix.red : pix.red - pix.green;
    end

    cls_next.d    = mx - mn;
    cls_next.t    = {1'b0, mx} + {1'b0, mn};
    cls_next.gray = (mx == mn);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      cls <= cls_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: dividends (960*|num|, 25600*d), saturation divisor, luminance.
  // Quotients stay below 2**15 since |num| <= d and d <= divisor.
  // --------------------------------------------------------------------------
  logic [DIV_NUM_W-1:0]  hue_num_next, sat_num_next;
  logic [DIV_DEN_W-1:0]  sat_den_next;
  logic [LUM_PROD_W-1:0] lum_prod;
  logic [CH_W:0]         t_inv;
  side_t                 side_next;

  logic [DIV_NUM_W-1:0] hue_num, sat_num;
  logic [DIV_DEN_W-1:0] hue_den, sat_den;
  side_t                side1;

  always_comb begin
    hue_num_next = DIV_NUM_W'({cls.anum, 10'b0}) - DIV_NUM_W'({cls.anum, 6'b0});
    sat_num_next = DIV_NUM_W'({cls.d, 14'b0}) + DIV_NUM_W'({cls.d, 13'b0})
                 + DIV_NUM_W'({cls.d, 10'b0});
    t_inv        = 9'd510 - cls.t;
    sat_den_next = (cls.t <= 9'd255) ? cls.t[CH_W-1:0] : t_inv[CH_W-1:0];
    lum_prod     = LUM_PROD_W'(cls.t) * LUM_PROD_W'(LUM_MAGIC);

    side_next.gray = cls.gray;
    side_next.neg  = cls.neg;
    side_next.base = cls.base;
    side_next.lum  = lum_prod[LUM_SHIFT +: PCT_W];
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      hue_num <= hue_num_next;
      hue_den <= cls.d;
      sat_num <= sat_num_next;
      sat_den <= sat_den_next;
      side1   <= side_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 2..16: two dividers in lockstep, side data delayed alongside.
  // A gray pixel divides by zero; its quotients are discarded at the end.
  // --------------------------------------------------------------------------
  logic [DIV_QUO_W-1:0] hue_q, sat_q;
  logic                 hue_rnz;
  side_t                side [DIV_QUO_W];

  rhsl_div #(
    .NUM_W(DIV_NUM_W),
    .DEN_W(DIV_DEN_W),
    .QUO_W(DIV_QUO_W)
  ) u_hue_div (
    .clk   (clk),
    .en    (adv[DIV_LO +: DIV_QUO_W]),
    .num   (hue_num),
    .den   (hue_den),
    .quo   (hue_q),
    .rem_nz(hue_rnz)
  );

  rhsl_div #(
    .NUM_W(DIV_NUM_W),
    .DEN_W(DIV_DEN_W),
    .QUO_W(DIV_QUO_W)
  ) u_sat_div (
    .clk   (clk),
    .en    (adv[DIV_LO +: DIV_QUO_W]),
    .num   (sat_num),
    .den   (sat_den),
    .quo   (sat_q),
    .rem_nz()
  );

  always_ff @(posedge clk) begin
    if (adv[DIV_LO]) begin
      side[0] <= side1;
    end
    for (int k = 1; k < DIV_QUO_W; k++) begin
      if (adv[DIV_LO + k]) begin
        side[k] <= side[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 17: hue = base +/- quotient; a negative numerator floors, so a
  // nonzero remainder takes one more off. Clamp everything, zero gray.
  // --------------------------------------------------------------------------
  side_t          side_o;
  logic [HUE_W:0] hue_sum;
  hsl_t           hsl_next;

  assign side_o = side[DIV_QUO_W-1];

  always_comb begin
    if (side_o.neg) begin
      hue_sum = {1'b0, side_o.base} - (HUE_W+1)'(hue_q) - (HUE_W+1)'(hue_rnz);
    end else begin
      hue_sum = {1'b0, side_o.base} + (HUE_W+1)'(hue_q);
    end

    if (side_o.gray) begin
      hsl_next.hue        = '0;
      hsl_next.saturation = '0;
    end else begin
      hsl_next.hue        = (hue_sum > {1'b0, HUE_MAX}) ? HUE_MAX : hue_sum[HUE_W-1:0];
      hsl_next.saturation = (sat_q > PCT_MAX) ? PCT_MAX : sat_q;
    end
    hsl_next.luminance = (side_o.lum > PCT_MAX) ? PCT_MAX : side_o.lum;
  end

  always_ff @(posedge clk) begin
    if (adv[NSTG-1]) begin
      hsl <= hsl_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // An empty output stage must let the whole pipeline move.
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    !hsl_valid |-> !pix_stall)
    else $error("input stalled with an empty output stage");

  // Backpressure at the input only when the output is blocked.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> (hsl_valid && hsl_stall))
    else $error("input stalled while output is free");

  // Results stay inside their ranges.
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    hsl_valid |-> (hsl.hue <= HUE_MAX && hsl.saturation <= PCT_MAX &&
                   hsl.luminance <= PCT_MAX))
    else $error("result out of range");

  // A colored pixel (nonzero hue) always has nonzero saturation.
  a_hue_implies_sat: assert property (@(posedge clk) disable iff (rst)
    (hsl_valid && hsl.hue != '0) |-> (hsl.saturation != '0))
    else $error("nonzero hue with zero saturation");
`endif

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: regression for rgb_to_hsl_converter_core
// A short table of known pixels comes first: black, white, the primaries and
// secondaries, grays, max-channel ties, the hue wrap and the saturation split
// at max+min = 255. Biased random pixels follow in three idle mixes, with one
// long output hold that backs the pipeline up. Every result is checked in order
// against an integer HSL predictor or against the value in the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import rhsl_pkg::*;

  localparam int N_DIRECTED       = 22;
  localparam int N_RANDOM_PHASE   = 350;
  localparam int RESET_CYCLES     = 11;
  localparam int LONG_HOLD_CYCLES = 300;
  // Outlasts the pipeline, so this catches any stray trailing result.
  localparam int SETTLE_CYCLES    = 40;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int REPORT_LIMIT     = 10;

  // One hue sector is 60 degrees, which is 960 sixteenths.
  localparam int HUE_PER_SECTOR = 960;
  // max+min runs 0..510. At or below the split, saturation divides by max+min.
  localparam int SUM_FULL_SCALE = 510;
  localparam int SAT_SPLIT      = 255;

  // One stimulus row: the pixel, plus a typed-in result where it is obvious.
  typedef struct packed {
    pixel_t px;
    logic   has_want;
    hsl_t   want;
  } stim_row_t;

  logic   clk       = 1'b0;
  logic   rst       = 1'b1;
  logic   pix_valid = 1'b0;
  logic   pix_stall;
  pixel_t pix       = '0;
  logic   hsl_valid;
  logic   hsl_stall = 1'b0;
  hsl_t   hsl;

  int src_idle_pct = 31;
  int dst_idle_pct = 51;
  int hold_reqs    = 0;
  int holds_done   = 0;
  int cycle_count  = 0;
  int err_count    = 0;
  int results_seen = 0;
  int pixels_sent  = 0;

  // Rows in the order they are offered. The monitor pops one per accepted item.
  stim_row_t offered_q[$];
  // Results still owed by the block, oldest first.
  hsl_t      pending_hsl[$];

  // Directed pixels. The rows with has_want = 0 are checked by the predictor.
  stim_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{'{8'd0,   8'd0,   8'd0  }, 1'b1, '{13'd0,    15'd0,     15'd0    }}, // black
    '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{13'd0,    15'd0,     15'd25600}}, // white
    '{'{8'd255, 8'd0,   8'd0  }, 1'b1, '{13'd0,    15'd25600, 15'd12800}}, // red
    '{'{8'd0,   8'd255, 8'd0  }, 1'b1, '{13'd1920, 15'd25600, 15'd12800}}, // green
    '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{13'd3840, 15'd25600, 15'd12800}}, // blue
    '{'{8'd255, 8'd255, 8'd0  }, 1'b1, '{13'd960,  15'd25600, 15'd12800}}, // r=g tie
    '{'{8'd0,   8'd255, 8'd255}, 1'b1, '{13'd2880, 15'd25600, 15'd12800}}, // g=b tie
    '{'{8'd255, 8'd0,   8'd255}, 1'b1, '{13'd4800, 15'd25600, 15'd12800}}, // r=b, wrap
    '{'{8'd128, 8'd128, 8'd128}, 1'b0, '0},  // mid gray
    '{'{8'd1,   8'd1,   8'd1  }, 1'b0, '0},  // near-black gray
    '{'{8'd255, 8'd0,   8'd1  }, 1'b0, '0},  // hue just under full circle
    '{'{8'd1,   8'd0,   8'd0  }, 1'b0, '0},
    '{'{8'd0,   8'd1,   8'd0  }, 1'b0, '0},
    '{'{8'd0,   8'd0,   8'd1  }, 1'b0, '0},
    '{'{8'd200, 8'd55,  8'd100}, 1'b0, '0},  // max+min = 255, low branch
    '{'{8'd201, 8'd55,  8'd100}, 1'b0, '0},  // max+min = 256, high branch
    '{'{8'd255, 8'd254, 8'd254}, 1'b0, '0},
    '{'{8'd254, 8'd255, 8'd255}, 1'b0, '0},
    '{'{8'hAA,  8'h55,  8'hAA }, 1'b0, '0},
    '{'{8'h55,  8'hAA,  8'h55 }, 1'b0, '0},
    '{'{8'h0F,  8'hF0,  8'h3C }, 1'b0, '0},
    '{'{8'h80,  8'h7F,  8'h01 }, 1'b0, '0}
  };

  rgb_to_hsl_converter_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .hsl_valid (hsl_valid),
    .hsl_stall (hsl_stall),
    .hsl       (hsl)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Integer HSL of one pixel: hue in 1/16 degree, saturation and luminance
  // in 1/256 percent, every quotient truncated and then clamped.
  function automatic hsl_t hsl_of_pixel(input pixel_t p);
    int   r, g, b, mx, mn, span, sum, num, base, hn, den, q;
    hsl_t res;
    r    = p.red;
    g    = p.green;
    b    = p.blue;
    mx   = (r > g) ? r : g;
    mx   = (b > mx) ? b : mx;
    mn   = (r < g) ? r : g;
    mn   = (b < mn) ? b : mn;
    span = mx - mn;
    sum  = mx + mn;
    res  = '0;
    if (span > 0) begin
      // Max-channel sector. On a tie red wins over green, green over blue.
      if (mx == r) begin
        num  = g - b;
        base = (g >= b) ? int'(HUE_BASE_RED) : int'(HUE_BASE_WRAP);
      end else if (mx == g) begin
        num  = b - r;
        base = int'(HUE_BASE_GRN);
      end else begin
        num  = r - g;
        base = int'(HUE_BASE_BLU);
      end
      hn = HUE_PER_SECTOR * num + base * span;
      if (hn < 0) hn = 0;
      q = hn / span;
      res.hue = (q > int'(HUE_MAX)) ? HUE_MAX : q[HUE_W-1:0];
      den = (sum <= SAT_SPLIT) ? sum : SUM_FULL_SCALE - sum;
      if (den != 0) begin
        q = int'(PCT_MAX) * span / den;
        res.saturation = (q > int'(PCT_MAX)) ? PCT_MAX : q[PCT_W-1:0];
      end
    end
    q = int'(PCT_MAX) * sum / SUM_FULL_SCALE;
    res.luminance = (q > int'(PCT_MAX)) ? PCT_MAX : q[PCT_W-1:0];
    return res;
  endfunction

  function automatic logic [CH_W-1:0] corner_code();
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // Random pixel, biased toward grays, channel ties, extremes and the
  // max+min = 255 split where the saturation divisor changes.
  function automatic stim_row_t random_row();
    stim_row_t row;
    int        lo, hi, mid, rot;
    row           = '0;
    row.px.red    = CH_W'($urandom);
    row.px.green  = CH_W'($urandom);
    row.px.blue   = CH_W'($urandom);
    case ($urandom_range(9))
      5: begin
        row.px.green = row.px.red;
        row.px.blue  = row.px.red;
      end
      6: begin
        case ($urandom_range(2))
          0:       row.px.green = row.px.red;
          1:       row.px.blue  = row.px.red;
          default: row.px.blue  = row.px.green;
        endcase
      end
      7: begin
        row.px.red   = corner_code();
        row.px.green = corner_code();
        row.px.blue  = corner_code();
      end
      8: begin
        // max+min lands on 254, 255 or 256. The channels are rotated so that
        // each one gets to be the max.
        hi  = $urandom_range(128, 255);
        lo  = SAT_SPLIT - hi + $urandom_range(2) - 1;
        lo  = (lo < 0) ? 0 : ((lo > hi) ? hi : lo);
        mid = $urandom_range(hi, lo);
        rot = $urandom_range(2);
        case (rot)
          0:       row.px = '{CH_W'(hi),  CH_W'(lo),  CH_W'(mid)};
          1:       row.px = '{CH_W'(mid), CH_W'(hi),  CH_W'(lo)};
          default: row.px = '{CH_W'(lo),  CH_W'(mid), CH_W'(hi)};
        endcase
      end
      9: begin
        // Tiny spans near black or white.
        hi = $urandom_range(1) ? 252 : 0;
        row.px.red   = CH_W'(hi + $urandom_range(3));
        row.px.green = CH_W'(hi + $urandom_range(3));
        row.px.blue  = CH_W'(hi + $urandom_range(3));
      end
      default: ;
    endcase
    return row;
  endfunction

  // Offer one pixel and return at the edge where it is taken. Valid stays
  // high afterward, so back-to-back items never toggle it within one step.
  task automatic offer_pixel(input stim_row_t row);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    offered_q.push_back(row);
    pix       <= row.px;
    pix_valid <= 1'b1;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
  endtask

  // Stop sending and wait until every owed result has come out.
  task automatic wait_drained();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (pending_hsl.size() != 0) @(posedge clk);
  endtask

  // Output side. A hold request stalls the output for a long stretch, so
  // the pipeline fills and the input stall has to rise.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        hsl_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        hsl_stall <= ($urandom_range(99) < dst_idle_pct);
      end
    end
  end

  // Monitor. Handshakes are sampled at the rising edge. Both sides are
  // driven by NBAs, so the values seen here are the ones from before the edge.
  always @(posedge clk) begin
    stim_row_t row;
    hsl_t      want;
    cycle_count++;
    if (!rst && pix_valid && !pix_stall) begin
      row = offered_q.pop_front();
      pending_hsl.push_back(row.has_want ? row.want : hsl_of_pixel(pix));
      pixels_sent++;
    end
    if (!rst && hsl_valid && !hsl_stall) begin
      results_seen++;
      if (pending_hsl.size() == 0) begin
        if (err_count < REPORT_LIMIT)
          $display("unexpected result: hue %0d sat %0d lum %0d",
                   hsl.hue, hsl.saturation, hsl.luminance);
        err_count++;
      end else begin
        want = pending_hsl.pop_front();
        if (hsl.hue !== want.hue || hsl.saturation !== want.saturation ||
            hsl.luminance !== want.luminance) begin
          if (err_count < REPORT_LIMIT)
            $display("result %0d mismatch: hue %0d/%0d sat %0d/%0d lum %0d/%0d (exp/got)",
                     results_seen, want.hue, hsl.hue, want.saturation,
                     hsl.saturation, want.luminance, hsl.luminance);
          err_count++;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results owed", cycle_count,
               pending_hsl.size());
      $display("rgb_to_hsl_converter_core regression: fail");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    int i;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Input idles 31% and output 51%. The directed table goes first.
    for (i = 0; i < N_DIRECTED; i++) offer_pixel(directed_rows[i]);
    for (i = 0; i < N_RANDOM_PHASE; i++) offer_pixel(random_row());
    wait_drained();

    // Swap the idle rates.
    src_idle_pct = 51;
    dst_idle_pct = 31;
    for (i = 0; i < N_RANDOM_PHASE; i++) offer_pixel(random_row());
    wait_drained();

    // Full rate. It opens with one long output hold while the input keeps
    // pushing, which drives the input stall.
    src_idle_pct = 0;
    dst_idle_pct = 0;
    hold_reqs++;
    for (i = 0; i < N_RANDOM_PHASE; i++) offer_pixel(random_row());
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("checked %0d results for %0d pixels (%0d from the table, rest random)",
             results_seen, pixels_sent, N_DIRECTED);
    $display("idle mixes 31/51, 51/31, none; %0d long output hold(s); %0d error(s)",
             holds_done, err_count);
    if (err_count == 0) begin
      $display("rgb_to_hsl_converter_core regression: pass");
    end else begin
      $display("rgb_to_hsl_converter_core regression: fail");
    end
    $finish;
  end

endmodule
